FILE: rtl/bsls_pkg.sv
// ----------------------------------------------------------------------------
// bsls_pkg
// Shared types and constants for the bounded sequence list store.
// ----------------------------------------------------------------------------
package bsls_pkg;

	// Default number of elements the store holds
	localparam int CAPACITY_DEF = 16;

	// Element word width
	localparam int ELEM_W = 32;

	// Request actions
	typedef enum logic [2:0] {
		ACT_INS_FRONT = 3'd0,
		ACT_INS_BACK  = 3'd1,
		ACT_INS_AT    = 3'd2,
		ACT_RM_FRONT  = 3'd3,
		ACT_RM_BACK   = 3'd4,
		ACT_RM_AT     = 3'd5,
		ACT_DUMP_FWD  = 3'd6,
		ACT_DUMP_REV  = 3'd7
	} action_t;

	// Result status codes
	typedef enum logic [1:0] {
		STAT_OK    = 2'd0,
		STAT_EMPTY = 2'd1,
		STAT_RANGE = 2'd2,
		STAT_FULL  = 2'd3
	} status_t;

	// Sequencer states
	typedef enum logic [2:0] {
		S_IDLE,
		S_SH_RD,
		S_SH_WR,
		S_DUMP_RD,
		S_DUMP_WAIT,
		S_RESP
	} state_t;

	// Result load from the sequencer into the output register
	typedef struct packed {
		logic                     load;
		logic signed [ELEM_W-1:0] element;
		status_t                  status;
		logic                     last;
	} res_t;

endpackage

FILE: rtl/bsls_if.sv
// ----------------------------------------------------------------------------
// bsls_if
// Request and result channel interfaces with valid/ready handshake.
// ----------------------------------------------------------------------------
interface bsls_req_if;
	logic                              valid;
	logic                              ready;
	bsls_pkg::action_t                 action;
	logic signed [bsls_pkg::ELEM_W-1:0] value;
	logic [4:0]                        position;

	modport source (output valid, output action, output value, output position, input ready);
	modport sink   (input valid, input action, input value, input position, output ready);
endinterface

interface bsls_rsp_if;
	logic                              valid;
	logic                              ready;
	logic signed [bsls_pkg::ELEM_W-1:0] element;
	bsls_pkg::status_t                 status;
	logic                              last;

	modport source (output valid, output element, output status, output last, input ready);
	modport sink   (input valid, input element, input status, input last, output ready);
endinterface

FILE: rtl/bsls_mem.sv
// ----------------------------------------------------------------------------
// bsls_mem
// Element storage: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module bsls_mem #(
	parameter int DEPTH = bsls_pkg::CAPACITY_DEF,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic                               clk,
	input  logic                               we,
	input  logic [AW-1:0]                      waddr,
	input  logic signed [bsls_pkg::ELEM_W-1:0] wdata,
	input  logic                               re,
	input  logic [AW-1:0]                      raddr,
	output logic signed [bsls_pkg::ELEM_W-1:0] rdata
);

	logic signed [bsls_pkg::ELEM_W-1:0] mem_q [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Read port; hold the last word read until the next read
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

FILE: rtl/bsls_ctrl.sv
// ----------------------------------------------------------------------------
// bsls_ctrl
// Request decode and sequencer; one shared index step and compare walks the
// storage for shifts and dumps.
// ----------------------------------------------------------------------------
module bsls_ctrl #(
	parameter int CAPACITY = bsls_pkg::CAPACITY_DEF,
	localparam int AW = $clog2(CAPACITY),
	localparam int CW = $clog2(CAPACITY + 1)
) (
	input  logic                               clk,
	input  logic                               arst_n,
	bsls_req_if.sink                           req,
	input  logic                               out_free,
	output bsls_pkg::res_t                     res,
	output logic                               mem_we,
	output logic [AW-1:0]                      mem_waddr,
	output logic signed [bsls_pkg::ELEM_W-1:0] mem_wdata,
	output logic                               mem_re,
	output logic [AW-1:0]                      mem_raddr,
	input  logic signed [bsls_pkg::ELEM_W-1:0] mem_rdata
);

	localparam int CMPW = (CW > 5) ? CW : 5;

	bsls_pkg::state_t  state_q, state_d;
	bsls_pkg::status_t stat_q, stat_d;
	logic [CW-1:0]     count_q, count_d;
	logic [AW-1:0]     idx_q, idx_d;
	logic [AW-1:0]     lim_q, lim_d;
	logic              up_q, up_d;
	logic              ins_q, ins_d;
	logic signed [bsls_pkg::ELEM_W-1:0] value_q, value_d;

	logic [CMPW-1:0] cnt_x;
	logic [CMPW-1:0] pos_x;
	logic [CMPW-1:0] ins_at;
	logic [CMPW-1:0] rm_at;
	logic [AW-1:0]   nb;
	logic            hit;

	// Shared index unit: one step and one end-of-walk compare
	assign nb  = up_q ? (idx_q + 1'b1) : (idx_q - 1'b1);
	assign hit = (idx_q == lim_q);

	// Target positions of the request
	assign cnt_x = CMPW'(count_q);
	assign pos_x = CMPW'(req.position);

	always_comb begin
		case (req.action)
			bsls_pkg::ACT_INS_FRONT: ins_at = '0;
			bsls_pkg::ACT_INS_BACK:  ins_at = cnt_x;
			default:                 ins_at = pos_x;
		endcase
		case (req.action)
			bsls_pkg::ACT_RM_FRONT: rm_at = '0;
			bsls_pkg::ACT_RM_BACK:  rm_at = cnt_x - 1'b1;
			default:                rm_at = pos_x;
		endcase
	end

	// State and working registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bsls_pkg::S_IDLE;
			count_q <= '0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
		end
	end

	always_ff @(posedge clk) begin
		stat_q  <= stat_d;
		idx_q   <= idx_d;
		lim_q   <= lim_d;
		up_q    <= up_d;
		ins_q   <= ins_d;
		value_q <= value_d;
	end

	// Next state and outputs
	always_comb begin
		state_d     = state_q;
		count_d     = count_q;
		stat_d      = stat_q;
		idx_d       = idx_q;
		lim_d       = lim_q;
		up_d        = up_q;
		ins_d       = ins_q;
		value_d     = value_q;
		req.ready   = 1'b0;
		res.load    = 1'b0;
		res.element = '0;
		res.status  = bsls_pkg::STAT_OK;
		res.last    = 1'b1;
		mem_we      = 1'b0;
		mem_waddr   = idx_q;
		mem_wdata   = mem_rdata;
		mem_re      = 1'b0;
		mem_raddr   = idx_q;

		unique case (state_q)
			bsls_pkg::S_IDLE: begin
				req.ready = 1'b1;
				if (req.valid) begin
					unique case (req.action)
						bsls_pkg::ACT_INS_FRONT, bsls_pkg::ACT_INS_BACK,
						bsls_pkg::ACT_INS_AT: begin
							if (ins_at > cnt_x) begin
								stat_d  = bsls_pkg::STAT_RANGE;
								state_d = bsls_pkg::S_RESP;
							end else if (cnt_x == CMPW'(CAPACITY)) begin
								stat_d  = bsls_pkg::STAT_FULL;
								state_d = bsls_pkg::S_RESP;
							end else begin
								stat_d  = bsls_pkg::STAT_OK;
								idx_d   = AW'(count_q);
								lim_d   = AW'(ins_at);
								up_d    = 1'b0;
								ins_d   = 1'b1;
								value_d = req.value;
								state_d = bsls_pkg::S_SH_RD;
							end
						end
						bsls_pkg::ACT_RM_FRONT, bsls_pkg::ACT_RM_BACK,
						bsls_pkg::ACT_RM_AT: begin
							if (count_q == '0) begin
								stat_d  = bsls_pkg::STAT_EMPTY;
								state_d = bsls_pkg::S_RESP;
							end else if (rm_at >= cnt_x) begin
								stat_d  = bsls_pkg::STAT_RANGE;
								state_d = bsls_pkg::S_RESP;
							end else begin
								stat_d  = bsls_pkg::STAT_OK;
								idx_d   = AW'(rm_at);
								lim_d   = AW'(cnt_x - 1'b1);
								up_d    = 1'b1;
								ins_d   = 1'b0;
								state_d = bsls_pkg::S_SH_RD;
							end
						end
						default: begin
							if (count_q == '0) begin
								stat_d  = bsls_pkg::STAT_EMPTY;
								state_d = bsls_pkg::S_RESP;
							end else if (req.action == bsls_pkg::ACT_DUMP_FWD) begin
								idx_d   = '0;
								lim_d   = AW'(cnt_x - 1'b1);
								up_d    = 1'b1;
								state_d = bsls_pkg::S_DUMP_RD;
							end else begin
								idx_d   = AW'(cnt_x - 1'b1);
								lim_d   = '0;
								up_d    = 1'b0;
								state_d = bsls_pkg::S_DUMP_RD;
							end
						end
					endcase
				end
			end

			// Fetch the neighbour, or finish the shift
			bsls_pkg::S_SH_RD: begin
				if (hit) begin
					if (ins_q) begin
						mem_we    = 1'b1;
						mem_wdata = value_q;
						count_d   = count_q + 1'b1;
					end else begin
						count_d   = count_q - 1'b1;
					end
					state_d = bsls_pkg::S_RESP;
				end else begin
					mem_re    = 1'b1;
					mem_raddr = nb;
					state_d   = bsls_pkg::S_SH_WR;
				end
			end

			// Move the fetched neighbour into the current slot and advance
			bsls_pkg::S_SH_WR: begin
				mem_we  = 1'b1;
				idx_d   = nb;
				state_d = bsls_pkg::S_SH_RD;
			end

			bsls_pkg::S_DUMP_RD: begin
				mem_re  = 1'b1;
				state_d = bsls_pkg::S_DUMP_WAIT;
			end

			// Hand one element on once the output register is free
			bsls_pkg::S_DUMP_WAIT: begin
				if (out_free) begin
					res.load    = 1'b1;
					res.element = mem_rdata;
					res.last    = hit;
					if (hit) begin
						state_d = bsls_pkg::S_IDLE;
					end else begin
						idx_d   = nb;
						state_d = bsls_pkg::S_DUMP_RD;
					end
				end
			end

			bsls_pkg::S_RESP: begin
				if (out_free) begin
					res.load   = 1'b1;
					res.status = stat_q;
					state_d    = bsls_pkg::S_IDLE;
				end
			end

			default: state_d = bsls_pkg::S_IDLE;
		endcase
	end

	// Checks
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(CAPACITY))
		else $error("element count above capacity");

	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q != $past(count_q)) |->
		(count_q == $past(count_q) + 1'b1) || (count_q == $past(count_q) - 1'b1))
		else $error("element count moved by more than one");

	a_leave_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(req.valid && req.ready) |=> (state_q != bsls_pkg::S_IDLE))
		else $error("accepted request left no work");

	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		res.load |-> out_free)
		else $error("result loaded into a full output register");

endmodule

FILE: rtl/bounded_sequence_list_store.sv
// ----------------------------------------------------------------------------
// bounded_sequence_list_store
// Ordered store of up to CAPACITY signed words with deque, positional and
// dump requests.
// ----------------------------------------------------------------------------
// One request is taken at a time; ready is high whenever the sequencer is
// idle, even while the previous result still waits in the output register.
// A rejected request (empty, out of range, full) goes from the accept cycle
// straight to the status cycle. An insert or remove that moves k elements
// runs the accept cycle, a read then a write for each move (read data from
// the element memory is registered), a step that writes the new element or
// drops the count, and the status cycle; k is count - position for an
// insert and count - position - 1 for a remove, so front operations are the
// slowest and back operations the fastest. A dump of n elements runs the
// accept cycle, then one memory read and one output load per element. The
// status and each output load wait while a stalled receiver holds the
// output register. No clearing pass follows reset: storage is only read
// below the element count.
module bounded_sequence_list_store #(
	parameter int CAPACITY = bsls_pkg::CAPACITY_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	bsls_req_if.sink   req,
	bsls_rsp_if.source rsp
);

	localparam int AW = $clog2(CAPACITY);

	bsls_pkg::res_t                     res;
	logic                               out_free;
	logic                               mem_we;
	logic [AW-1:0]                      mem_waddr;
	logic signed [bsls_pkg::ELEM_W-1:0] mem_wdata;
	logic                               mem_re;
	logic [AW-1:0]                      mem_raddr;
	logic signed [bsls_pkg::ELEM_W-1:0] mem_rdata;

	logic                               out_vld_q;
	logic signed [bsls_pkg::ELEM_W-1:0] out_elem_q;
	bsls_pkg::status_t                  out_stat_q;
	logic                               out_last_q;

	bsls_mem #(
		.DEPTH (CAPACITY)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	bsls_ctrl #(
		.CAPACITY (CAPACITY)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.out_free  (out_free),
		.res       (res),
		.mem_we    (mem_we),
		.mem_waddr (mem_waddr),
		.mem_wdata (mem_wdata),
		.mem_re    (mem_re),
		.mem_raddr (mem_raddr),
		.mem_rdata (mem_rdata)
	);

	// Output register is free when empty or being taken this cycle
	assign out_free = !out_vld_q || rsp.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (res.load) begin
			out_vld_q <= 1'b1;
		end else if (rsp.ready) begin
			out_vld_q <= 1'b0;
		end
	end

	// Hold the result payload until it is taken
	always_ff @(posedge clk) begin
		if (res.load) begin
			out_elem_q <= res.element;
			out_stat_q <= res.status;
			out_last_q <= res.last;
		end
	end

	assign rsp.valid   = out_vld_q;
	assign rsp.element = out_elem_q;
	assign rsp.status  = out_stat_q;
	assign rsp.last    = out_last_q;

endmodule
